// ===== src/lzt_pkg.sv =====
// Shared types, constants and controller/datapath interface for the layer z-order table.
package lzt_pkg;

  localparam int ID_W        = 8;
  localparam int LVL_W       = 9;
  localparam int REQ_W       = 10;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + ID_W + LVL_W + LVL_W + 1);

  typedef logic signed [LVL_W-1:0] level_t;
  typedef logic signed [REQ_W-1:0] req_t;

  localparam logic   OP_ALLOC  = 1'b0;
  localparam logic   OP_SET    = 1'b1;
  localparam level_t LVL_NONE  = level_t'(-1);
  localparam level_t LVL_ONE   = level_t'(1);
  localparam req_t   REQ_NONE  = req_t'(-1);
  localparam req_t   REQ_ONE   = req_t'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_PLAN,
    ST_SHIFT,
    ST_DRAIN,
    ST_PUT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic alloc_hit;
    logic alloc_miss;
    logic plan_set;
    logic reject;
    logic shift_issue;
    logic put;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_free;
    logic scan_last;
    logic id_bad;
    logic lvl_same;
    logic n_zero;
    logic shift_last;
  } stat_t;

endpackage

// ===== src/layer_zorder_table.sv =====
// Layer z-order table: allocate slots in one word, move layers in the stacking order in the other.
// Allocate: the scan runs from slot 0 to the lowest free slot k, or to slot 255 on a full table.
// Set level: n entries are shifted (at most 255), none when n is 0; a rejected request or an
//   unchanged level does no shift.
// One word in flight; the next word is taken the cycle after its result enters the output register.
// Synchronous active-low reset clears slot flags, sets the top level to -1; memories keep contents.
module layer_zorder_table #(
  parameter int MAX_LAYERS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] layer_id, [17:8] requested_level, [23:18] zero
  input  logic [lzt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] opcode
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] ok, [8:1] result_layer, [17:9] final_level, [26:18] top_level, [27] redraw,
  // [31:28] zero
  output logic [lzt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  lzt_pkg::cmd_t  cmd;
  lzt_pkg::stat_t stat;

  lzt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lzt_dp #(.MAX_LAYERS(MAX_LAYERS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

// ===== src/lzt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lzt_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lzt_ctrl.sv =====
// Controller state machine: sequences allocate scans, level moves and result hand-off.
module lzt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [0:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  lzt_pkg::stat_t stat,
  output lzt_pkg::cmd_t  cmd
);

  lzt_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      lzt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_tuser[0] == lzt_pkg::OP_SET) ? lzt_pkg::ST_PLAN : lzt_pkg::ST_ALLOC;
        end
      end
      lzt_pkg::ST_ALLOC: begin
        priority if (stat.scan_free) begin
          cmd.alloc_hit = 1'b1;
          state_nxt     = lzt_pkg::ST_DONE;
        end else if (stat.scan_last) begin
          cmd.alloc_miss = 1'b1;
          state_nxt      = lzt_pkg::ST_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      lzt_pkg::ST_PLAN: begin
        priority if (stat.id_bad) begin
          cmd.reject = 1'b1;
          state_nxt  = lzt_pkg::ST_DONE;
        end else if (stat.lvl_same) begin
          cmd.plan_set = 1'b1;
          state_nxt    = lzt_pkg::ST_DONE;
        end else if (stat.n_zero) begin
          cmd.plan_set = 1'b1;
          state_nxt    = lzt_pkg::ST_PUT;
        end else begin
          cmd.plan_set = 1'b1;
          state_nxt    = lzt_pkg::ST_SHIFT;
        end
      end
      lzt_pkg::ST_SHIFT: begin
        cmd.shift_issue = 1'b1;
        if (stat.shift_last) begin
          state_nxt = lzt_pkg::ST_DRAIN;
        end
      end
      lzt_pkg::ST_DRAIN: begin
        state_nxt = lzt_pkg::ST_PUT;
      end
      lzt_pkg::ST_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = lzt_pkg::ST_DONE;
      end
      lzt_pkg::ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = lzt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lzt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_tready  = (state_r == lzt_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ===== src/lzt_dp.sv =====
// Datapath: slot flags, order and level memories, level clamp and move planning, result register.
module lzt_dp #(
  parameter int MAX_LAYERS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lzt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]                      in_tuser,
  input  lzt_pkg::cmd_t                   cmd,
  output lzt_pkg::stat_t                  stat,
  output logic [lzt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int DEPTH = (MAX_LAYERS < 256) ? MAX_LAYERS : 256;
  localparam int AW    = $clog2(DEPTH);

  // accepted word
  logic                      op_r;
  logic [lzt_pkg::ID_W-1:0]  id_r;
  lzt_pkg::req_t             req_r;

  // block state
  logic [DEPTH-1:0]          used_r;
  lzt_pkg::level_t           top_r, top_nxt;
  logic [AW-1:0]             scan_r;

  // move plan
  lzt_pkg::level_t           lv_r;
  logic                      hide_r, show_r, step_neg_r;
  lzt_pkg::level_t           rd_pos_r, wr_pos_r;
  logic [lzt_pkg::LVL_W-1:0] rem_r;
  logic                      rd_vld_r;

  // result
  logic                      res_ok_r, res_redraw_r;
  logic [lzt_pkg::ID_W-1:0]  res_layer_r;
  lzt_pkg::level_t           res_final_r;
  logic [lzt_pkg::OUT_TDATA_W-1:0] out_data_r;

  // memories
  logic [AW-1:0]             ord_rdata, ord_waddr, ord_wdata;
  logic                      ord_we;
  lzt_pkg::level_t           lvl_rdata, lvl_wdata;
  logic [AW-1:0]             lvl_waddr;
  logic                      lvl_we;

  // planning
  lzt_pkg::req_t             old_w, top_w, hi_w, lv_min, lv_c, dst0, n_w, step_w;
  logic                      down_c, hide_c, show_c, step_neg_c;
  lzt_pkg::level_t           step_r;

  lzt_ram #(.W(AW), .DEPTH(DEPTH)) u_order (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .re    (cmd.shift_issue),
    .raddr (rd_pos_r[AW-1:0]),
    .rdata (ord_rdata)
  );

  lzt_ram #(.W(lzt_pkg::LVL_W), .DEPTH(DEPTH)) u_level (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .re    (cmd.accept),
    .raddr (in_tdata[AW-1:0]),
    .rdata (lvl_rdata)
  );

  // clamp the request and work out the shift run
  always_comb begin
    old_w  = lzt_pkg::req_t'(lvl_rdata);
    top_w  = lzt_pkg::req_t'(top_r);
    hi_w   = lvl_rdata[lzt_pkg::LVL_W-1] ? top_w + lzt_pkg::REQ_ONE : top_w;
    lv_min = (req_r > hi_w) ? hi_w : req_r;
    lv_c   = (lv_min < lzt_pkg::REQ_NONE) ? lzt_pkg::REQ_NONE : lv_min;
    down_c = (lv_c < old_w);
    hide_c = down_c && lv_c[lzt_pkg::REQ_W-1];
    show_c = !down_c && lvl_rdata[lzt_pkg::LVL_W-1];
    priority if (hide_c) begin
      n_w        = top_w - old_w;
      step_neg_c = 1'b0;
    end else if (down_c) begin
      n_w        = old_w - lv_c;
      step_neg_c = 1'b1;
    end else if (show_c) begin
      n_w        = top_w + lzt_pkg::REQ_ONE - lv_c;
      step_neg_c = 1'b1;
    end else begin
      n_w        = lv_c - old_w;
      step_neg_c = 1'b0;
    end
    dst0   = show_c ? top_w + lzt_pkg::REQ_ONE : old_w;
    step_w = step_neg_c ? lzt_pkg::REQ_NONE : lzt_pkg::REQ_ONE;
  end

  assign step_r = step_neg_r ? lzt_pkg::LVL_NONE : lzt_pkg::LVL_ONE;

  // memory write selection
  always_comb begin
    ord_we    = rd_vld_r || (cmd.put && !hide_r);
    ord_waddr = rd_vld_r ? wr_pos_r[AW-1:0] : lv_r[AW-1:0];
    ord_wdata = rd_vld_r ? ord_rdata : id_r[AW-1:0];
    lvl_we    = cmd.alloc_hit || rd_vld_r || cmd.put;
    priority if (cmd.alloc_hit) begin
      lvl_waddr = scan_r;
      lvl_wdata = lzt_pkg::LVL_NONE;
    end else if (rd_vld_r) begin
      lvl_waddr = ord_rdata;
      lvl_wdata = wr_pos_r;
    end else begin
      lvl_waddr = id_r[AW-1:0];
      lvl_wdata = lv_r;
    end
  end

  always_comb begin
    priority if (cmd.put && hide_r) begin
      top_nxt = top_r + lzt_pkg::LVL_NONE;
    end else if (cmd.put && show_r) begin
      top_nxt = top_r + lzt_pkg::LVL_ONE;
    end else begin
      top_nxt = top_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      top_r    <= lzt_pkg::LVL_NONE;
      scan_r   <= '0;
      rd_vld_r <= 1'b0;
      rem_r    <= '0;
    end else begin
      top_r    <= top_nxt;
      rd_vld_r <= cmd.shift_issue;
      if (cmd.accept) begin
        scan_r <= '0;
      end else if (cmd.scan_step) begin
        scan_r <= scan_r + AW'(1);
      end
      if (cmd.alloc_hit) begin
        used_r[scan_r] <= 1'b1;
      end
      if (cmd.plan_set) begin
        rem_r <= n_w[lzt_pkg::LVL_W-1:0];
      end else if (cmd.shift_issue) begin
        rem_r <= rem_r - lzt_pkg::LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_tuser[0];
      id_r  <= in_tdata[lzt_pkg::ID_W-1:0];
      req_r <= in_tdata[lzt_pkg::ID_W +: lzt_pkg::REQ_W];
    end
    if (cmd.plan_set) begin
      lv_r       <= lzt_pkg::level_t'(lv_c);
      hide_r     <= hide_c;
      show_r     <= show_c;
      step_neg_r <= step_neg_c;
      wr_pos_r   <= lzt_pkg::level_t'(dst0);
      rd_pos_r   <= lzt_pkg::level_t'(dst0 + step_w);
    end else begin
      if (cmd.shift_issue) begin
        rd_pos_r <= rd_pos_r + step_r;
      end
      if (rd_vld_r) begin
        wr_pos_r <= wr_pos_r + step_r;
      end
    end
    priority if (cmd.alloc_hit) begin
      res_ok_r     <= 1'b1;
      res_layer_r  <= lzt_pkg::ID_W'(scan_r);
      res_final_r  <= lzt_pkg::LVL_NONE;
      res_redraw_r <= 1'b0;
    end else if (cmd.alloc_miss) begin
      res_ok_r     <= 1'b0;
      res_layer_r  <= '0;
      res_final_r  <= lzt_pkg::LVL_NONE;
      res_redraw_r <= 1'b0;
    end else if (cmd.reject) begin
      res_ok_r     <= 1'b0;
      res_layer_r  <= id_r;
      res_final_r  <= lzt_pkg::LVL_NONE;
      res_redraw_r <= 1'b0;
    end else if (cmd.plan_set) begin
      res_ok_r     <= 1'b1;
      res_layer_r  <= id_r;
      res_final_r  <= lzt_pkg::level_t'(lv_c);
      res_redraw_r <= (lv_c != old_w);
    end else begin
      res_ok_r     <= res_ok_r;
    end
    if (cmd.load_out) begin
      out_data_r <= {{lzt_pkg::OUT_PAD_W{1'b0}}, res_redraw_r, top_r, res_final_r,
                     res_layer_r, res_ok_r};
    end
  end

  always_comb begin
    stat            = '0;
    stat.scan_free  = !used_r[scan_r];
    stat.scan_last  = (scan_r == AW'(DEPTH - 1));
    stat.id_bad     = ({1'b0, id_r} >= 9'(DEPTH)) || !used_r[id_r[AW-1:0]] ||
                      (op_r != lzt_pkg::OP_SET);
    stat.lvl_same   = (lv_c == old_w);
    stat.n_zero     = (n_w == '0);
    stat.shift_last = (rem_r == lzt_pkg::LVL_W'(1));
  end

  assign out_tdata = out_data_r;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r && cmd.shift_issue) |-> (rd_pos_r[AW-1:0] != wr_pos_r[AW-1:0]))
    else $error("order table read and write collide during shift");

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r >= lzt_pkg::LVL_NONE) && (top_r < DEPTH))
    else $error("top level out of range");

  a_top_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.put |=> $stable(top_r))
    else $error("top level changed outside a put");

  a_used_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_hit |=> used_r[$past(scan_r)] && $stable(top_r))
    else $error("allocated slot not marked used");

endmodule
